/* hw/rtl/tbs_pkg.sv */
`timescale 1ns / 1ps
package tbs_pkg;

  // Default queue depths, register reset values and counter limit
  localparam int unsigned WAIT_DEPTH_DEF  = 64;
  localparam int unsigned READY_DEPTH_DEF = 64;
  localparam logic [7:0]  DEPTH_RST       = 8'd10;
  localparam logic [15:0] SEQ_RST         = 16'd1;
  localparam logic [15:0] CNT_MAX         = 16'hFFFF;

  // Input commands
  typedef enum logic [1:0] {
    CMD_ARRIVE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_SERVE  = 2'd2,
    CMD_NONE   = 2'd3
  } tbs_cmd_e;

  // Result event kinds
  typedef enum logic [2:0] {
    EVT_ENQUEUED   = 3'd0,
    EVT_DROP_BIG   = 3'd1,
    EVT_DROP_FULL  = 3'd2,
    EVT_TOKEN_KEPT = 3'd3,
    EVT_TOKEN_DROP = 3'd4,
    EVT_MOVED      = 3'd5,
    EVT_SERVED     = 3'd6,
    EVT_NONE_READY = 3'd7
  } tbs_evt_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_TICK,
    ST_MOVE,
    ST_SERVE
  } tbs_state_e;

  // Input item
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  tokens_needed;
    logic [15:0] service_time;
  } tbs_in_t;

  // Result item
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] packet_number;
    logic [7:0]  tokens_held;
    logic [15:0] packet_service_time;
    logic [15:0] token_number;
    logic [15:0] packet_drops;
    logic        last;
  } tbs_out_t;

  // Queue entries
  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  need;
    logic [15:0] svc;
  } tbs_wait_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] svc;
  } tbs_rdy_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic arrive;
    logic tick;
    logic move_emit;
    logic serve;
  } tbs_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic move_ok;
  } tbs_sts_t;

endpackage

/* hw/rtl/tbs_ram.sv */
`timescale 1ns / 1ps
module tbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port (read returns old data)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tbs_ctrl.sv */
`timescale 1ns / 1ps
module tbs_ctrl
  import tbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] cmd_i,
  input  tbs_sts_t   sts_i,
  output tbs_ctl_t   ctl_o,
  output logic       busy_o
);

  tbs_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (tbs_cmd_e'(cmd_i))
            CMD_ARRIVE: state_d = ST_ARRIVE;
            CMD_TICK:   state_d = ST_TICK;
            CMD_SERVE:  state_d = ST_SERVE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ARRIVE: state_d = ST_IDLE;
      ST_TICK:   state_d = sts_i.move_ok ? ST_MOVE : ST_IDLE;
      ST_MOVE:   state_d = ST_IDLE;
      ST_SERVE:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        ctl_o.capture = start_i;
      end
      ST_ARRIVE: ctl_o.arrive    = 1'b1;
      ST_TICK:   ctl_o.tick      = 1'b1;
      ST_MOVE:   ctl_o.move_emit = 1'b1;
      ST_SERVE:  ctl_o.serve     = 1'b1;
      default:   busy_o          = 1'b1;
    endcase
  end

endmodule

/* hw/rtl/tbs_dp.sv */
`timescale 1ns / 1ps
module tbs_dp
  import tbs_pkg::*;
#(
  parameter int unsigned WAIT_DEPTH  = WAIT_DEPTH_DEF,
  parameter int unsigned READY_DEPTH = READY_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tbs_ctl_t   ctl_i,
  output tbs_sts_t   sts_o,
  input  tbs_in_t    in_i,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  output logic       result_valid_o,
  output tbs_out_t   result_o
);

  localparam int unsigned WAW = $clog2(WAIT_DEPTH);
  localparam int unsigned WCW = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned RAW = $clog2(READY_DEPTH);
  localparam int unsigned RCW = $clog2(READY_DEPTH + 1);

  // Control state
  logic [7:0]     depth_q, level_q, level_d;
  logic [15:0]    tick_q, tick_d, drops_q, drops_d, seq_q, seq_d;
  logic [WAW-1:0] whead_q, whead_d, wtail_q, wtail_d;
  logic [WCW-1:0] wcnt_q, wcnt_d;
  logic [RAW-1:0] rhead_q, rhead_d, rtail_q, rtail_d;
  logic [RCW-1:0] rcnt_q, rcnt_d;
  logic           rvalid_q;

  // Payload
  tbs_in_t   item_q;
  tbs_out_t  result_q, result_d, mv_q, mv_d;
  tbs_wait_t wait_wdata, wait_head;
  tbs_rdy_t  rdy_wdata, rdy_head;
  logic      wait_we, rdy_we;

  logic [7:0]  level_inc;
  logic [15:0] drops_inc;
  logic        too_big, wfull, rempty, rfull, move_ok;

  tbs_ram #(.WIDTH($bits(tbs_wait_t)), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (wtail_q),
    .wdata_i (wait_wdata),
    .raddr_i (whead_q),
    .rdata_o (wait_head)
  );

  tbs_ram #(.WIDTH($bits(tbs_rdy_t)), .DEPTH(READY_DEPTH)) u_rdy_ram (
    .clk_i   (clk_i),
    .we_i    (rdy_we),
    .waddr_i (rtail_q),
    .wdata_i (rdy_wdata),
    .raddr_i (rhead_q),
    .rdata_o (rdy_head)
  );

  // Shared conditions
  assign level_inc = (level_q < depth_q) ? level_q + 8'd1 : level_q;
  assign drops_inc = (drops_q == CNT_MAX) ? drops_q : drops_q + 16'd1;
  assign too_big   = item_q.tokens_needed > depth_q;
  assign wfull     = wcnt_q == WCW'(WAIT_DEPTH);
  assign rempty    = rcnt_q == '0;
  assign rfull     = rcnt_q == RCW'(READY_DEPTH);
  assign move_ok   = (wcnt_q != '0) && !rfull && (level_inc >= wait_head.need);
  assign sts_o.move_ok = move_ok;

  // Queue writes
  assign wait_we    = ctl_i.arrive && !too_big && !wfull;
  assign wait_wdata = '{seq: seq_q, need: item_q.tokens_needed, svc: item_q.service_time};
  assign rdy_we     = ctl_i.tick && move_ok;
  assign rdy_wdata  = '{seq: wait_head.seq, svc: wait_head.svc};

  // Event processing
  always_comb begin
    level_d  = level_q;
    tick_d   = tick_q;
    drops_d  = drops_q;
    seq_d    = seq_q;
    whead_d  = whead_q;
    wtail_d  = wtail_q;
    wcnt_d   = wcnt_q;
    rhead_d  = rhead_q;
    rtail_d  = rtail_q;
    rcnt_d   = rcnt_q;
    mv_d     = mv_q;
    result_d = result_q;

    if (ctl_i.arrive) begin
      seq_d = seq_q + 16'd1;
      result_d.event_kind = EVT_ENQUEUED;
      if (too_big) begin
        drops_d = drops_inc;
        result_d.event_kind = EVT_DROP_BIG;
      end else if (wfull) begin
        drops_d = drops_inc;
        result_d.event_kind = EVT_DROP_FULL;
      end else begin
        wtail_d = (wtail_q == WAW'(WAIT_DEPTH - 1)) ? '0 : wtail_q + WAW'(1);
        wcnt_d  = wcnt_q + WCW'(1);
      end
      result_d.packet_number       = seq_q;
      result_d.tokens_held         = level_q;
      result_d.packet_service_time = item_q.service_time;
      result_d.token_number        = tick_q;
      result_d.packet_drops        = drops_d;
      result_d.last                = 1'b1;
    end

    if (ctl_i.tick) begin
      tick_d = tick_q + 16'd1;
      // token result, then the move result is staged for the next cycle
      result_d.event_kind = (level_q < depth_q) ? EVT_TOKEN_KEPT : EVT_TOKEN_DROP;
      result_d.packet_number       = '0;
      result_d.tokens_held         = level_inc;
      result_d.packet_service_time = '0;
      result_d.token_number        = tick_d;
      result_d.packet_drops        = drops_q;
      result_d.last                = !move_ok;
      level_d = level_inc;
      if (move_ok) begin
        level_d = level_inc - wait_head.need;
        whead_d = (whead_q == WAW'(WAIT_DEPTH - 1)) ? '0 : whead_q + WAW'(1);
        wcnt_d  = wcnt_q - WCW'(1);
        rtail_d = (rtail_q == RAW'(READY_DEPTH - 1)) ? '0 : rtail_q + RAW'(1);
        rcnt_d  = rcnt_q + RCW'(1);
      end
      mv_d.event_kind          = EVT_MOVED;
      mv_d.packet_number       = wait_head.seq;
      mv_d.tokens_held         = level_d;
      mv_d.packet_service_time = wait_head.svc;
      mv_d.token_number        = tick_d;
      mv_d.packet_drops        = drops_q;
      mv_d.last                = 1'b1;
    end

    if (ctl_i.move_emit) begin
      result_d = mv_q;
    end

    if (ctl_i.serve) begin
      result_d.tokens_held  = level_q;
      result_d.token_number = tick_q;
      result_d.packet_drops = drops_q;
      result_d.last         = 1'b1;
      if (!rempty) begin
        result_d.event_kind          = EVT_SERVED;
        result_d.packet_number       = rdy_head.seq;
        result_d.packet_service_time = rdy_head.svc;
        rhead_d = (rhead_q == RAW'(READY_DEPTH - 1)) ? '0 : rhead_q + RAW'(1);
        rcnt_d  = rcnt_q - RCW'(1);
      end else begin
        result_d.event_kind          = EVT_NONE_READY;
        result_d.packet_number       = '0;
        result_d.packet_service_time = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= DEPTH_RST;
      level_q  <= '0;
      tick_q   <= '0;
      drops_q  <= '0;
      seq_q    <= SEQ_RST;
      whead_q  <= '0;
      wtail_q  <= '0;
      wcnt_q   <= '0;
      rhead_q  <= '0;
      rtail_q  <= '0;
      rcnt_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        depth_q <= cfg_data_i;
      end
      level_q  <= level_d;
      tick_q   <= tick_d;
      drops_q  <= drops_d;
      seq_q    <= seq_d;
      whead_q  <= whead_d;
      wtail_q  <= wtail_d;
      wcnt_q   <= wcnt_d;
      rhead_q  <= rhead_d;
      rtail_q  <= rtail_d;
      rcnt_q   <= rcnt_d;
      rvalid_q <= ctl_i.arrive | ctl_i.tick | ctl_i.move_emit | ctl_i.serve;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      item_q <= in_i;
    end
    result_q <= result_d;
    mv_q     <= mv_d;
  end

  assign result_valid_o = rvalid_q;
  assign result_o       = result_q;

endmodule

/* hw/rtl/token_bucket_two_queue_shaper.sv */
`timescale 1ns / 1ps
// Token bucket shaper with a wait queue and a ready queue.
// Items: an item is taken at a rising edge with start high and busy low.
//   cmd 0 is a packet arrival, 1 a token tick, 2 a server request; cmd 3 is
//   taken and ignored, giving no result.
// Results: each result item sits on result_o for one cycle, flagged by
//   result_valid_o; the receiver has no way to hold them off. The final
//   result of an item carries last = 1.
// Timing: the first result is registered in the ARRIVE, TICK or SERVE state
//   entered at the accepting edge. A tick that moves a packet to the ready
//   queue gives a second result from the MOVE state, in the cycle after the
//   first.
// Items in flight: the block takes no new item until the last is done; each
//   item spends a busy ARRIVE, TICK or SERVE state, and a moving tick a MOVE
//   state too, in the controller. The queue heads are read from registered-read
//   RAMs while it is idle. An ignored cmd 3 item leaves the block idle.
// Configuration: bucket_depth is written through cfg_valid_i / cfg_data_i;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce; cfg_ready_o is always high.
// Reset: rst_ni clears the bucket, counters and both queues to empty, sets
//   the next sequence number to 1 and bucket_depth to 10. No clearing pass.
module token_bucket_two_queue_shaper
  import tbs_pkg::*;
#(
  parameter int unsigned WAIT_DEPTH  = WAIT_DEPTH_DEF,
  parameter int unsigned READY_DEPTH = READY_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  tbs_in_t    in_i,
  output logic       result_valid_o,
  output tbs_out_t   result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  tbs_ctl_t ctl;
  tbs_sts_t sts;

  // Sequencer
  tbs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (in_i.cmd),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  // Bucket, counters and queues
  tbs_dp #(
    .WAIT_DEPTH  (WAIT_DEPTH),
    .READY_DEPTH (READY_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .in_i           (in_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  assign cfg_ready_o = 1'b1;

endmodule

/* tb/tb_token_bucket_two_queue_shaper.sv */
`timescale 1ns / 1ps
module tb_token_bucket_two_queue_shaper
  import tbs_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;
  // Ways of choosing tokens_needed for random arrivals
  localparam int NEED_LOW  = 0;
  localparam int NEED_WIDE = 1;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  tbs_in_t    in_i        = '0;
  logic       result_valid_o;
  tbs_out_t   result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = '0;

  token_bucket_two_queue_shaper dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shaper state as the block should hold it
  logic [7:0]  bkt_depth  = DEPTH_RST;
  logic [7:0]  bkt_level  = '0;
  logic [15:0] tick_total = '0;
  logic [15:0] drop_total = '0;
  logic [15:0] next_seq   = SEQ_RST;
  tbs_wait_t   waiting[$];
  tbs_rdy_t    ready_pkts[$];

  tbs_out_t    expected_events[$];
  tbs_out_t    exp_ev;
  int          errors = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;

  // Result item for the current counters and level
  function automatic tbs_out_t make_event(tbs_evt_e kind, logic [15:0] pkt,
                                          logic [15:0] svc);
    tbs_out_t ev;
    ev.event_kind          = kind;
    ev.packet_number       = pkt;
    ev.tokens_held         = bkt_level;
    ev.packet_service_time = svc;
    ev.token_number        = tick_total;
    ev.packet_drops        = drop_total;
    ev.last                = 1'b0;
    return ev;
  endfunction

  // Advance the shaper by one item and queue the events it produces
  function automatic void shape_item(tbs_in_t it);
    tbs_out_t    evs[$];
    tbs_wait_t   hd;
    tbs_rdy_t    rh;
    logic [15:0] seq;
    tbs_evt_e    kind;
    case (it.cmd)
      CMD_ARRIVE: begin
        seq      = next_seq;
        next_seq = next_seq + 16'd1;
        if (it.tokens_needed > bkt_depth) begin
          if (drop_total != CNT_MAX) drop_total++;
          kind = EVT_DROP_BIG;
        end else if (waiting.size() >= WAIT_DEPTH_DEF) begin
          if (drop_total != CNT_MAX) drop_total++;
          kind = EVT_DROP_FULL;
        end else begin
          hd.seq  = seq;
          hd.need = it.tokens_needed;
          hd.svc  = it.service_time;
          waiting.push_back(hd);
          kind = EVT_ENQUEUED;
        end
        evs.push_back(make_event(kind, seq, it.service_time));
      end
      CMD_TICK: begin
        tick_total = tick_total + 16'd1;
        if (bkt_level < bkt_depth) begin
          bkt_level++;
          kind = EVT_TOKEN_KEPT;
        end else begin
          kind = EVT_TOKEN_DROP;
        end
        evs.push_back(make_event(kind, '0, '0));
        // head moves only when tokens suffice and the ready side has room
        if (waiting.size() > 0 && ready_pkts.size() < READY_DEPTH_DEF) begin
          hd = waiting[0];
          if (bkt_level >= hd.need) begin
            bkt_level = bkt_level - hd.need;
            void'(waiting.pop_front());
            rh.seq = hd.seq;
            rh.svc = hd.svc;
            ready_pkts.push_back(rh);
            evs.push_back(make_event(EVT_MOVED, hd.seq, hd.svc));
          end
        end
      end
      CMD_SERVE: begin
        if (ready_pkts.size() > 0) begin
          rh = ready_pkts.pop_front();
          evs.push_back(make_event(EVT_SERVED, rh.seq, rh.svc));
        end else begin
          evs.push_back(make_event(EVT_NONE_READY, '0, '0));
        end
      end
      default: ;
    endcase
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endfunction

  function automatic tbs_in_t mk(tbs_cmd_e c, logic [7:0] need, logic [15:0] svc);
    tbs_in_t it;
    it.cmd           = c;
    it.tokens_needed = need;
    it.service_time  = svc;
    return it;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Present one item and hold it until taken
  task automatic send_item(input tbs_in_t it);
    int gap;
    gap = pick_gap();
    start <= 1'b1;
    in_i  <= it;
    do @(posedge clk_i); while (busy);
    shape_item(it);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait for all events; ignored items may still be in flight
  task automatic wait_quiet();
    start <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_depth(input logic [7:0] value);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bkt_depth = value;
  endtask

  // Weighted random traffic; ignored commands do not count toward n
  task automatic random_traffic(input int n, input int w_arrive, input int w_tick,
                                input int need_mode);
    int       done;
    int       r;
    tbs_cmd_e c;
    logic [7:0] need;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 3)                      c = CMD_NONE;
      else if (r < 3 + w_arrive)      c = CMD_ARRIVE;
      else if (r < 3 + w_arrive + w_tick) c = CMD_TICK;
      else                            c = CMD_SERVE;
      if (need_mode == NEED_LOW)
        need = ($urandom_range(0, 9) < 8) ? 8'd0 : 8'd1;
      else if ($urandom_range(0, 1) == 0)
        need = 8'($urandom_range(0, 15));
      else
        need = 8'($urandom_range(0, 255));
      send_item(mk(c, need, 16'($urandom_range(0, 65535))));
      if (c != CMD_NONE) done++;
    end
  endtask

  // Arrivals at the reset depth: fits, exact fit, too big; empty serve; unused cmd
  task automatic test_arrivals();
    send_item(mk(CMD_ARRIVE, 8'd0, 16'h0000));
    send_item(mk(CMD_ARRIVE, 8'd10, 16'hFFFF));
    send_item(mk(CMD_ARRIVE, 8'd11, 16'h1234));
    send_item(mk(CMD_ARRIVE, 8'd255, 16'hFFFF));
    send_item(mk(CMD_SERVE, 8'hFF, 16'hFFFF));
    send_item(mk(CMD_NONE, 8'hFF, 16'hFFFF));
  endtask

  // Ticks fill the bucket and move both waiting packets, then serve them
  task automatic test_ticks();
    repeat (10) send_item(mk(CMD_TICK, 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535))));
    send_item(mk(CMD_SERVE, 8'd0, 16'd0));
    send_item(mk(CMD_SERVE, 8'd0, 16'd0));
  endtask

  // Depth 1: token overflow, move spending all tokens, too big at new depth
  task automatic test_token_overflow();
    set_depth(8'd1);
    send_item(mk(CMD_TICK, 8'd0, 16'd0));
    send_item(mk(CMD_TICK, 8'd0, 16'd0));
    send_item(mk(CMD_ARRIVE, 8'd1, 16'hA5A5));
    send_item(mk(CMD_TICK, 8'd0, 16'd0));
    send_item(mk(CMD_ARRIVE, 8'd2, 16'h5A5A));
    send_item(mk(CMD_SERVE, 8'd0, 16'd0));
  endtask

  // Arrival heavy, no serves, back to back: the wait queue overflows
  task automatic test_wait_queue_fill();
    set_depth(8'd255);
    idle_on = 1'b0;
    random_traffic(100, 88, 9, NEED_LOW);
    idle_on = 1'b1;
  endtask

  // Tick heavy, no serves: every tick moves until the ready queue is full
  task automatic test_ready_queue_fill();
    set_depth(8'd200);
    random_traffic(100, 10, 87, NEED_LOW);
  endtask

  // Depth 0 under a full bucket: tokens dropped, ready queue drained
  task automatic test_depth_below_level();
    set_depth(8'd0);
    random_traffic(100, 15, 25, NEED_WIDE);
  endtask

  // Mixed traffic over several random depths
  task automatic test_mixed_traffic();
    repeat (4) begin
      set_depth(8'($urandom_range(0, 255)));
      random_traffic(30, 40, 35, NEED_WIDE);
    end
  endtask

  // Compare each result item with the oldest expected one
  task automatic check_field(input string name, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result item, event_kind %0d", result_o.event_kind);
        errors++;
      end else begin
        exp_ev = expected_events.pop_front();
        check_field("event_kind", 32'(exp_ev.event_kind), 32'(result_o.event_kind));
        check_field("packet_number", 32'(exp_ev.packet_number),
                    32'(result_o.packet_number));
        check_field("tokens_held", 32'(exp_ev.tokens_held), 32'(result_o.tokens_held));
        check_field("packet_service_time", 32'(exp_ev.packet_service_time),
                    32'(result_o.packet_service_time));
        check_field("token_number", 32'(exp_ev.token_number),
                    32'(result_o.token_number));
        check_field("packet_drops", 32'(exp_ev.packet_drops),
                    32'(result_o.packet_drops));
        check_field("last", 32'(exp_ev.last), 32'(result_o.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_arrivals();
    test_ticks();
    test_token_overflow();
    test_wait_queue_fill();
    test_ready_queue_fill();
    test_depth_below_level();
    test_mixed_traffic();
    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
